// File: rtl/core/markov_melody_step_sampler_top_macros.svh
// ----------------------------------------------------------------------------
// Markov melody step sampler assertion macros
// Concurrent assertion wrappers clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MARKOV_MELODY_STEP_SAMPLER_TOP_MACROS_SVH
`define MARKOV_MELODY_STEP_SAMPLER_TOP_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define MMS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MMS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/mms_pkg.sv
// ----------------------------------------------------------------------------
// Markov melody step sampler package
// Transaction payload types, function codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package mms_pkg;

	localparam logic [1:0] FUNC_LOAD       = 2'd0;
	localparam logic [1:0] FUNC_STEP       = 2'd1;
	localparam logic [1:0] FUNC_BIASED     = 2'd2;
	localparam logic [1:0] FUNC_CLEAR_HIST = 2'd3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_DEGREES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEAP_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEAP_BOOST     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DAMPING = 2'd3;

	localparam logic [4:0]  ACTIVE_DEGREES_RST = 5'd16;
	localparam logic [3:0]  LEAP_THRESHOLD_RST = 4'd2;
	localparam logic [15:0] LEAP_BOOST_RST     = 16'd4096;
	localparam logic [15:0] REPEAT_DAMPING_RST = 16'd4096;

	localparam logic [15:0] Q12_ONE   = 16'd4096;
	localparam int          Q12_SHIFT = 12;
	localparam logic [16:0] BIAS_ONE  = 17'd65536;

	typedef struct packed {
		logic [1:0]         func;
		logic [3:0]         current_degree;
		logic [3:0]         column_index;
		logic [15:0]        weight_value;
		logic [31:0]        random_fraction;
		logic signed [15:0] target_position;
		logic [16:0]        bias_weight;
	} step_req_t;

	typedef struct packed {
		logic [3:0] next_degree;
		logic       leap_boost_applied;
		logic       damping_applied;
	} step_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/mms_chan_if.sv
// ----------------------------------------------------------------------------
// Markov melody step sampler channel
// Valid/ready channel; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface mms_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/markov_melody_step_sampler_top.sv
// ----------------------------------------------------------------------------
// Markov melody step sampler
// Samples the next scale degree from a loadable table of transition weights.
// The step_in channel carries weight loads, plain and biased steps and
// history clears; step_out carries one result transaction for each step.
// Loads and history clears complete on acceptance and give no result.
// A step walks the selected row of the weight RAM twice, once to form the
// shaped row sum and once to accumulate and compare, with shared multiplier
// work in ST_MUL in between. The row is read one entry at a time through the
// single read port of the weight RAM. Once the result is loaded into the
// output register, the next transaction can be taken in the cycle after.
// A finished result waits in the output register while step_in is open again;
// if the receiver stalls with that register full, the next step holds in its
// last cycle until the register frees up.
// After reset the weight RAM is swept to zero, one entry per cycle, over all
// MAX_DEGREES*MAX_DEGREES entries (256 by default) with step_in not ready.
// Configuration writes are taken at any time but must only be issued while idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "markov_melody_step_sampler_top_macros.svh"

module markov_melody_step_sampler_top #(
	parameter int MAX_DEGREES = 16,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mms_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mms_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	mms_chan_if.sink                        step_in,
	mms_chan_if.source                      step_out
);
	localparam int DEPTH = MAX_DEGREES * MAX_DEGREES;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = $clog2(MAX_DEGREES + 1);
	localparam int FW    = 33;
	localparam int RW    = WEIGHT_BITS + 16;
	localparam int PW    = WEIGHT_BITS + FW;
	localparam int SW    = RW + $clog2(MAX_DEGREES);
	localparam int CW    = SW + 17;
	localparam int TW    = 32 + SW;
	localparam int SLO   = (SW + 1) / 2;
	localparam int MW    = 33 + SLO;
	localparam int IW    = ((NW > 4) ? NW : 4) + 1;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_SETUP = 7'b0000100,
		ST_PASS1 = 7'b0001000,
		ST_MUL   = 7'b0010000,
		ST_PASS2 = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t                state_q;
	logic [4:0]            cfg_active_q;
	logic [3:0]            cfg_thr_q;
	logic [15:0]           cfg_boost_q;
	logic [15:0]           cfg_damp_q;
	logic                  hist_valid_q;
	logic [4:0]            last_int_q;
	logic                  last_rep_q;
	logic [AW-1:0]         clr_q;

	mms_pkg::step_req_t    req_q;
	logic [NW-1:0]         n_c, n_q, cur_c, cur_q, st_c, st_q, tdeg_c, tdeg_q;
	logic [NW-1:0]         cnt_q, j_s1, j_s2, chosen_q;
	logic [4:0]            mag_c;
	logic                  up_c, st_ok_c, leap_c, leap_hit_q, damp_hit_q;
	logic [8:0]            rnd_c;
	logic [16:0]           b_c, b_q, omb_c, omb_q;
	logic [FW-1:0]         mix_boost_q, mix_damp_q, mix_one_q, factor_c;

	logic                  issue_v, v_s1, v_s2, pass_end_c;
	logic [PW-1:0]         prod_c, prod_s2;
	logic [SW-1:0]         sum_q;
	logic                  uniform_q;
	logic [2:0]            k_q;
	logic [32:0]           mul_a_c;
	logic [SLO-1:0]        mul_b_c;
	logic [MW-1:0]         mp_c, mp_q;
	logic [TW-1:0]         thresh_q;
	logic [CW-1:0]         bsum_q, cum_q, term_c, addb_c, cum_c;
	logic                  hit_c, found_q;

	logic signed [IW-1:0]  ivl_c;
	logic [4:0]            ivl_sat_c;
	logic                  rep_c;

	logic                  in_acc, out_load_c, out_valid_q;
	mms_pkg::step_rsp_t    out_q;

	logic                  in_table_c;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr, ram_raddr, load_addr_c;
	logic [WEIGHT_BITS-1:0] ram_wdata, ram_rdata;

	assign step_in.ready  = (state_q == ST_IDLE);
	assign in_acc         = step_in.valid && step_in.ready;
	assign step_out.valid = out_valid_q;
	assign step_out.data  = out_q;
	assign out_load_c     = (state_q == ST_DONE) && (!out_valid_q || step_out.ready);

	always_comb begin
		if (cfg_active_q == '0) begin
			n_c = NW'(1);
		end else if (32'(cfg_active_q) > 32'(MAX_DEGREES)) begin
			n_c = NW'(MAX_DEGREES);
		end else begin
			n_c = NW'(cfg_active_q);
		end
	end

	always_comb begin
		if (req_q.current_degree < n_q) begin
			cur_c = NW'(req_q.current_degree);
		end else begin
			cur_c = n_q - NW'(1);
		end
		mag_c   = last_int_q[4] ? (~last_int_q + 5'd1) : last_int_q;
		up_c    = !last_int_q[4] && (last_int_q != '0);
		st_c    = up_c ? (cur_c - NW'(1)) : (cur_c + NW'(1));
		st_ok_c = up_c ? (cur_c != '0) : ((cur_c + NW'(1)) < n_q);
		leap_c  = hist_valid_q && (mag_c > {1'b0, cfg_thr_q}) && st_ok_c;
		if (req_q.func == mms_pkg::FUNC_BIASED) begin
			b_c = (req_q.bias_weight > mms_pkg::BIAS_ONE) ? mms_pkg::BIAS_ONE
				: req_q.bias_weight;
		end else begin
			b_c = '0;
		end
		omb_c = mms_pkg::BIAS_ONE - b_c;
		rnd_c = 9'(({1'b0, req_q.target_position} + 17'd128) >> 8);
		if (req_q.target_position[15]) begin
			tdeg_c = '0;
		end else if (rnd_c >= n_q) begin
			tdeg_c = n_q - NW'(1);
		end else begin
			tdeg_c = NW'(rnd_c);
		end
	end

	assign issue_v    = ((state_q == ST_PASS1) || (state_q == ST_PASS2)) && (cnt_q < n_q);
	assign pass_end_c = (cnt_q == n_q) && !v_s1 && !v_s2;
	assign ram_raddr  = AW'(32'(cur_q) * 32'(MAX_DEGREES) + 32'(cnt_q));

	always_comb begin
		if (state_q == ST_PASS1) begin
			if (damp_hit_q && (j_s1 == cur_q)) begin
				factor_c = FW'(cfg_damp_q);
			end else if (leap_hit_q && (j_s1 == st_q)) begin
				factor_c = FW'(cfg_boost_q);
			end else begin
				factor_c = FW'(mms_pkg::Q12_ONE);
			end
		end else begin
			if (damp_hit_q && (j_s1 == cur_q)) begin
				factor_c = mix_damp_q;
			end else if (leap_hit_q && (j_s1 == st_q)) begin
				factor_c = mix_boost_q;
			end else begin
				factor_c = mix_one_q;
			end
		end
	end

	assign prod_c  = PW'(ram_rdata) * PW'(factor_c);
	assign mul_a_c = k_q[1] ? 33'(b_q) : 33'(req_q.random_fraction);
	assign mul_b_c = k_q[0] ? SLO'(sum_q[SW-1:SLO]) : sum_q[SLO-1:0];
	assign mp_c    = MW'(mul_a_c) * MW'(mul_b_c);

	assign term_c = uniform_q ? CW'(omb_q) : CW'(prod_s2);
	assign addb_c = ((b_q != '0) && (j_s2 == tdeg_q)) ? bsum_q : '0;
	assign cum_c  = cum_q + term_c + addb_c;
	assign hit_c  = ({1'b0, thresh_q} <= {cum_c, 16'h0000});

	always_comb begin
		ivl_c = $signed(IW'(chosen_q)) - $signed(IW'(req_q.current_degree));
		rep_c = (ivl_c == '0);
		if (ivl_c > $signed(IW'(15))) begin
			ivl_sat_c = 5'd15;
		end else if (ivl_c < -$signed(IW'(16))) begin
			ivl_sat_c = 5'b10000;
		end else begin
			ivl_sat_c = 5'(ivl_c);
		end
	end

	assign in_table_c  = (32'(step_in.data.current_degree) < 32'(MAX_DEGREES))
		&& (32'(step_in.data.column_index) < 32'(MAX_DEGREES));
	assign load_addr_c = AW'(32'(step_in.data.current_degree) * 32'(MAX_DEGREES)
		+ 32'(step_in.data.column_index));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (in_acc && (step_in.data.func == mms_pkg::FUNC_LOAD) && in_table_c) begin
			ram_we    = 1'b1;
			ram_waddr = load_addr_c;
			ram_wdata = WEIGHT_BITS'(step_in.data.weight_value);
		end
	end

	mms_ram #(
		.WIDTH (WEIGHT_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cfg_active_q <= mms_pkg::ACTIVE_DEGREES_RST;
			cfg_thr_q    <= mms_pkg::LEAP_THRESHOLD_RST;
			cfg_boost_q  <= mms_pkg::LEAP_BOOST_RST;
			cfg_damp_q   <= mms_pkg::REPEAT_DAMPING_RST;
			hist_valid_q <= 1'b0;
			last_int_q   <= '0;
			last_rep_q   <= 1'b0;
			clr_q        <= '0;
			cnt_q        <= '0;
			k_q          <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			uniform_q    <= 1'b0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					mms_pkg::CFG_ACTIVE_DEGREES: cfg_active_q <= cfg_wdata[4:0];
					mms_pkg::CFG_LEAP_THRESHOLD: cfg_thr_q <= cfg_wdata[3:0];
					mms_pkg::CFG_LEAP_BOOST:     cfg_boost_q <= cfg_wdata;
					mms_pkg::CFG_REPEAT_DAMPING: cfg_damp_q <= cfg_wdata;
					default: ;
				endcase
			end

			v_s1 <= issue_v;
			v_s2 <= v_s1;
			if (issue_v) begin
				cnt_q <= cnt_q + NW'(1);
			end

			if (out_load_c) begin
				out_valid_q <= 1'b1;
			end else if (step_out.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						if (step_in.data.func == mms_pkg::FUNC_CLEAR_HIST) begin
							hist_valid_q <= 1'b0;
							last_int_q   <= '0;
							last_rep_q   <= 1'b0;
						end else if (step_in.data.func != mms_pkg::FUNC_LOAD) begin
							state_q <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					cnt_q     <= '0;
					uniform_q <= 1'b0;
					state_q   <= ST_PASS1;
				end
				ST_PASS1: begin
					if (pass_end_c) begin
						uniform_q <= (sum_q == '0);
						k_q       <= '0;
						state_q   <= ST_MUL;
					end
				end
				ST_MUL: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd4) begin
						cnt_q   <= '0;
						found_q <= 1'b0;
						state_q <= ST_PASS2;
					end
				end
				ST_PASS2: begin
					if (v_s2 && hit_c) begin
						found_q <= 1'b1;
					end
					if (pass_end_c) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load_c) begin
						hist_valid_q <= 1'b1;
						last_int_q   <= ivl_sat_c;
						last_rep_q   <= rep_c;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		j_s1    <= cnt_q;
		j_s2    <= j_s1;
		prod_s2 <= prod_c;
		mp_q    <= mp_c;

		if (in_acc) begin
			req_q <= step_in.data;
			n_q   <= n_c;
		end

		if (state_q == ST_SETUP) begin
			cur_q       <= cur_c;
			st_q        <= st_c;
			tdeg_q      <= tdeg_c;
			leap_hit_q  <= leap_c;
			damp_hit_q  <= last_rep_q;
			b_q         <= b_c;
			omb_q       <= omb_c;
			mix_boost_q <= FW'(cfg_boost_q) * FW'(omb_c);
			mix_damp_q  <= FW'(cfg_damp_q) * FW'(omb_c);
			mix_one_q   <= FW'(omb_c) << mms_pkg::Q12_SHIFT;
			sum_q       <= '0;
		end

		if ((state_q == ST_PASS1) && v_s2) begin
			sum_q <= sum_q + SW'(prod_s2);
		end
		if ((state_q == ST_PASS1) && pass_end_c && (sum_q == '0)) begin
			sum_q <= SW'(n_q);
		end

		if (state_q == ST_MUL) begin
			case (k_q)
				3'd1: thresh_q <= TW'(mp_q);
				3'd2: thresh_q <= thresh_q + (TW'(mp_q) << SLO);
				3'd3: bsum_q <= CW'(mp_q);
				3'd4: begin
					bsum_q   <= bsum_q + (CW'(mp_q) << SLO);
					cum_q    <= '0;
					chosen_q <= n_q - NW'(1);
				end
				default: ;
			endcase
		end

		if ((state_q == ST_PASS2) && v_s2) begin
			cum_q <= cum_c;
			if (hit_c && !found_q) begin
				chosen_q <= j_s2;
			end
		end

		if (out_load_c) begin
			out_q.next_degree        <= 4'(chosen_q);
			out_q.leap_boost_applied <= leap_hit_q;
			out_q.damping_applied    <= damp_hit_q;
		end
	end

	`MMS_ASSERT(a_ram_write_idle, ram_we |-> (state_q == ST_CLEAR || state_q == ST_IDLE), "weight RAM written during a step")
	`MMS_ASSERT(a_pipe_in_pass, v_s1 |-> (state_q == ST_PASS1 || state_q == ST_PASS2), "row read outside a pass")
	`MMS_ASSERT(a_chosen_in_row, (state_q == ST_DONE) |-> (chosen_q < n_q), "chosen degree beyond active count")
	`MMS_ASSERT(a_uniform_sum, (state_q == ST_PASS2 && uniform_q) |-> (sum_q == SW'(n_q)), "uniform row sum differs from count")
	`MMS_ASSERT_NEXT(a_result_out, out_load_c, out_valid_q && state_q == ST_IDLE, "result not presented")

endmodule

`default_nettype wire

// File: rtl/core/mms_ram.sv
// ----------------------------------------------------------------------------
// Markov melody step sampler RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

`default_nettype wire

// File: tb/mms_step_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Markov melody step sampler checker
// Watches the configuration port and both channels, predicts the result of
// every accepted step transaction and compares it with the block's output.
// ----------------------------------------------------------------------------
`default_nettype none

module mms_step_checker
	import mms_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  req_valid,
	input  logic                  req_ready,
	input  step_req_t             req_data,
	input  logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  step_rsp_t             rsp_data,
	output int                    results_due,
	output int                    error_count
);

	localparam int MAX_DEG = 16;

	logic [15:0] weights [MAX_DEG][MAX_DEG];
	logic        hist_valid;
	int          prev_interval;
	logic        prev_repeat;
	logic [4:0]  degrees_cfg;
	logic [3:0]  threshold_cfg;
	logic [15:0] boost_cfg;
	logic [15:0] damping_cfg;
	step_rsp_t   expected_steps [$];

	function automatic bit sample_next_degree(input step_req_t req, output step_rsp_t rsp);
		logic [63:0]  row [MAX_DEG];
		logic [63:0]  total;
		logic [16:0]  blend;
		logic [127:0] thresh, cum, keep_w, blend_w, total_w;
		int           n, cur, st, tdeg, chosen, t, ivl, mag;
		bit           found, leap_hit, damp_hit;

		rsp = '0;
		if (req.func == FUNC_LOAD) begin
			weights[req.current_degree][req.column_index] = req.weight_value;
			return 1'b0;
		end
		if (req.func == FUNC_CLEAR_HIST) begin
			hist_valid = 1'b0;
			prev_interval = 0;
			prev_repeat = 1'b0;
			return 1'b0;
		end

		n = int'(degrees_cfg);
		if (n < 1) n = 1;
		if (n > MAX_DEG) n = MAX_DEG;
		cur = (int'(req.current_degree) < n) ? int'(req.current_degree) : n - 1;
		leap_hit = 1'b0;
		damp_hit = 1'b0;

		for (int j = 0; j < n; j++)
			row[j] = 64'(weights[cur][j]) << Q12_SHIFT;

		if (hist_valid) begin
			mag = (prev_interval < 0) ? -prev_interval : prev_interval;
			if (mag > int'(threshold_cfg)) begin
				st = cur + ((prev_interval > 0) ? -1 : 1);
				if (st >= 0 && st < n) begin
					row[st] = 64'(weights[cur][st]) * 64'(boost_cfg);
					leap_hit = 1'b1;
				end
			end
		end
		if (prev_repeat) begin
			row[cur] = 64'(weights[cur][cur]) * 64'(damping_cfg);
			damp_hit = 1'b1;
		end

		total = '0;
		for (int j = 0; j < n; j++)
			total += row[j];
		if (total == 0) begin
			for (int j = 0; j < n; j++)
				row[j] = 64'd1;
			total = 64'(n);
		end

		blend = '0;
		tdeg = 0;
		if (req.func == FUNC_BIASED) begin
			blend = (req.bias_weight > BIAS_ONE) ? BIAS_ONE : req.bias_weight;
			t = int'($signed(req.target_position));
			if (t >= 0) t = (t + 128) >>> 8;
			else t = -((-t + 128) >>> 8);
			if (t < 0) t = 0;
			if (t >= n) t = n - 1;
			tdeg = t;
		end

		keep_w = BIAS_ONE - blend;
		blend_w = blend;
		total_w = total;
		thresh = (128'(req.random_fraction) * total_w) << 16;
		cum = '0;
		chosen = n - 1;
		found = 1'b0;
		for (int j = 0; j < n; j++) begin
			if (!found) begin
				cum += keep_w * 128'(row[j]);
				if (j == tdeg && blend != 0)
					cum += blend_w * total_w;
				if (thresh <= (cum << 32)) begin
					chosen = j;
					found = 1'b1;
				end
			end
		end

		ivl = chosen - int'(req.current_degree);
		prev_repeat = (ivl == 0);
		if (ivl > 15) ivl = 15;
		if (ivl < -16) ivl = -16;
		prev_interval = ivl;
		hist_valid = 1'b1;

		rsp.next_degree = 4'(chosen);
		rsp.leap_boost_applied = leap_hit;
		rsp.damping_applied = damp_hit;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		step_rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_DEG; i++)
				for (int j = 0; j < MAX_DEG; j++)
					weights[i][j] = '0;
			hist_valid = 1'b0;
			prev_interval = 0;
			prev_repeat = 1'b0;
			degrees_cfg = ACTIVE_DEGREES_RST;
			threshold_cfg = LEAP_THRESHOLD_RST;
			boost_cfg = LEAP_BOOST_RST;
			damping_cfg = REPEAT_DAMPING_RST;
			expected_steps.delete();
			error_count = 0;
			results_due <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ACTIVE_DEGREES: degrees_cfg = cfg_wdata[4:0];
					CFG_LEAP_THRESHOLD: threshold_cfg = cfg_wdata[3:0];
					CFG_LEAP_BOOST:     boost_cfg = cfg_wdata;
					CFG_REPEAT_DAMPING: damping_cfg = cfg_wdata;
					default: ;
				endcase
			end
			if (req_valid && req_ready) begin
				if (sample_next_degree(req_data, want))
					expected_steps.push_back(want);
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_steps.size() == 0) begin
					$display("%0t: unexpected result, got next_degree %0d leap %0b damping %0b",
						$time, rsp_data.next_degree, rsp_data.leap_boost_applied,
						rsp_data.damping_applied);
					error_count++;
				end else begin
					want = expected_steps.pop_front();
					if (rsp_data.next_degree !== want.next_degree ||
							rsp_data.leap_boost_applied !== want.leap_boost_applied ||
							rsp_data.damping_applied !== want.damping_applied) begin
						$display("%0t: mismatch, next_degree exp %0d got %0d, leap exp %0b got %0b, damping exp %0b got %0b",
							$time, want.next_degree, rsp_data.next_degree,
							want.leap_boost_applied, rsp_data.leap_boost_applied,
							want.damping_applied, rsp_data.damping_applied);
						error_count++;
					end
				end
			end
			results_due <= expected_steps.size();
		end
	end

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Markov melody step sampler testbench
// Loads weight rows and issues plain steps, biased steps and history clears
// under several register settings, with bursty input and a stalling output.
// A directed opening covers the corner cases before a long random run.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	import mms_pkg::*;

	localparam int STALL_LIMIT  = 4000;
	localparam int SETTLE       = 60;
	localparam int LONG_HOLD    = 600;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 133;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    results_due;
	int                    error_count;
	int                    burst_left;
	int                    gap_max;
	bit                    hold_wanted;
	bit                    hold_done;

	int unsigned phase_active [PHASES] = '{16, 0, 1, 2, 31, 17, 3, 5, 8, 12};
	int unsigned phase_thr    [PHASES] = '{0, 15, 0, 1, 3, 0, 2, 0, 1, 15};
	int unsigned phase_boost  [PHASES] = '{65535, 0, 4096, 12288, 65535, 1, 8192, 0, 40000, 2048};
	int unsigned phase_damp   [PHASES] = '{0, 65535, 4096, 65535, 1, 0, 2048, 30000, 8192, 65535};

	mms_chan_if #(.payload_t(step_req_t)) step_in_ch ();
	mms_chan_if #(.payload_t(step_rsp_t)) step_out_ch ();

	markov_melody_step_sampler_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.step_in   (step_in_ch),
		.step_out  (step_out_ch)
	);

	mms_step_checker step_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.req_valid   (step_in_ch.valid),
		.req_ready   (step_in_ch.ready),
		.req_data    (step_in_ch.data),
		.rsp_valid   (step_out_ch.valid),
		.rsp_ready   (step_out_ch.ready),
		.rsp_data    (step_out_ch.data),
		.results_due (results_due),
		.error_count (error_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic step_req_t make_req(input logic [1:0] func, input int unsigned cur,
			input int unsigned col, input int unsigned w, input logic [31:0] r,
			input logic [15:0] tgt, input logic [16:0] bias);
		step_req_t item;
		item.func = func;
		item.current_degree = 4'(cur);
		item.column_index = 4'(col);
		item.weight_value = 16'(w);
		item.random_fraction = r;
		item.target_position = tgt;
		item.bias_weight = bias;
		return item;
	endfunction

	function automatic step_req_t random_req(input int span);
		step_req_t item;
		int        pick;
		int        tpos;
		pick = $urandom_range(0, 99);
		if (pick < 28) item.func = FUNC_LOAD;
		else if (pick < 31) item.func = FUNC_CLEAR_HIST;
		else if (pick < 70) item.func = FUNC_STEP;
		else item.func = FUNC_BIASED;
		item.current_degree = ($urandom_range(0, 7) == 0) ? 4'($urandom)
			: 4'($urandom_range(0, span - 1));
		item.column_index = ($urandom_range(0, 3) == 0) ? 4'($urandom)
			: 4'($urandom_range(0, span - 1));
		pick = $urandom_range(0, 9);
		if (pick < 3) item.weight_value = '0;
		else if (pick == 3) item.weight_value = 16'hFFFF;
		else if (pick < 6) item.weight_value = 16'($urandom_range(1, 3));
		else item.weight_value = 16'($urandom);
		pick = $urandom_range(0, 19);
		if (pick == 0) item.random_fraction = '0;
		else if (pick == 1) item.random_fraction = '1;
		else item.random_fraction = $urandom;
		if ($urandom_range(0, 3) == 0) begin
			item.target_position = 16'($urandom);
		end else begin
			tpos = int'($urandom_range(0, span + 1)) * 256 - 256
				+ int'($urandom_range(0, 255)) - 128;
			item.target_position = 16'(tpos);
		end
		pick = $urandom_range(0, 9);
		if (pick == 0) item.bias_weight = '0;
		else if (pick == 1) item.bias_weight = BIAS_ONE;
		else if (pick == 2) item.bias_weight = 17'($urandom_range(0, 131071));
		else item.bias_weight = 17'($urandom_range(0, 65536));
		return item;
	endfunction

	task automatic offer(input step_req_t item);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				step_in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		step_in_ch.valid <= 1'b1;
		step_in_ch.data <= item;
		@(posedge clk);
		while (!step_in_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		step_in_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_config(input int unsigned active, input int unsigned thr,
			input int unsigned boost, input int unsigned damp);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ACTIVE_DEGREES;
		cfg_wdata <= 16'(active);
		@(posedge clk);
		cfg_index <= CFG_LEAP_THRESHOLD;
		cfg_wdata <= 16'(thr);
		@(posedge clk);
		cfg_index <= CFG_LEAP_BOOST;
		cfg_wdata <= 16'(boost);
		@(posedge clk);
		cfg_index <= CFG_REPEAT_DAMPING;
		cfg_wdata <= 16'(damp);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int span;
		int unsigned boost;
		int unsigned damp;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ACTIVE_DEGREES;
		cfg_wdata <= '0;
		step_in_ch.valid <= 1'b0;
		step_in_ch.data <= '0;
		burst_left = 0;
		gap_max = 3;
		hold_wanted = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		set_config(4, 1, 16'hFFFF, 16'h0800);
		offer(make_req(FUNC_CLEAR_HIST, 0, 0, 0, 32'h0, 16'h0, 17'h0));
		offer(make_req(FUNC_STEP, 0, 0, 0, 32'h0, 16'h0, 17'h0));
		offer(make_req(FUNC_STEP, 0, 0, 0, 32'hFFFF_FFFF, 16'h0, 17'h0));
		offer(make_req(FUNC_STEP, 3, 0, 0, 32'h8000_0000, 16'h0, 17'h0));
		offer(make_req(FUNC_LOAD, 3, 0, 16'hFFFF, 32'h0, 16'h0, 17'h0));
		offer(make_req(FUNC_LOAD, 3, 1, 0, 32'h0, 16'h0, 17'h0));
		offer(make_req(FUNC_LOAD, 3, 2, 1, 32'h0, 16'h0, 17'h0));
		offer(make_req(FUNC_LOAD, 3, 3, 16'h8000, 32'h0, 16'h0, 17'h0));
		offer(make_req(FUNC_LOAD, 15, 15, 16'hFFFF, 32'h0, 16'h0, 17'h0));
		offer(make_req(FUNC_LOAD, 0, 15, 16'hFFFF, 32'h0, 16'h0, 17'h0));
		offer(make_req(FUNC_STEP, 15, 0, 0, 32'h0, 16'h0, 17'h0));
		offer(make_req(FUNC_STEP, 3, 0, 0, 32'hFFFF_FFFF, 16'h0, 17'h0));
		offer(make_req(FUNC_BIASED, 3, 0, 0, 32'h4000_0000, 16'h8000, 17'h1FFFF));
		offer(make_req(FUNC_BIASED, 3, 0, 0, 32'hC000_0000, 16'h7FFF, BIAS_ONE));
		offer(make_req(FUNC_BIASED, 1, 0, 0, 32'h7FFF_FFFF, 16'h0180, 17'h08000));
		offer(make_req(FUNC_BIASED, 2, 0, 0, 32'h0, 16'hFE80, 17'h00001));
		offer(make_req(FUNC_BIASED, 2, 0, 0, 32'hFFFF_FFFF, 16'h0080, 17'h00000));
		offer(make_req(FUNC_LOAD, 0, 0, 16'h1234, 32'h0, 16'h0, 17'h0));
		offer(make_req(FUNC_STEP, 0, 0, 0, 32'h5555_5555, 16'h0, 17'h0));
		offer(make_req(FUNC_CLEAR_HIST, 0, 0, 0, 32'h0, 16'h0, 17'h0));
		offer(make_req(FUNC_STEP, 3, 0, 0, 32'hFFFF_FFFF, 16'h0, 17'h0));

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			boost = phase_boost[phase];
			damp = phase_damp[phase];
			if (phase >= 6) begin
				boost = $urandom_range(0, 65535);
				damp = $urandom_range(0, 65535);
			end
			set_config(phase_active[phase], phase_thr[phase], boost, damp);
			span = int'(phase_active[phase]);
			if (span < 1) span = 1;
			if (span > 16) span = 16;
			case (phase % 3)
				0: gap_max = 0;
				1: gap_max = 4;
				default: gap_max = 30;
			endcase
			if (phase == 2)
				hold_wanted = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++)
				offer(random_req(span));
		end

		drain();
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		int mode;
		int span;
		int period;
		step_out_ch.ready <= 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_wanted && !hold_done) begin
				hold_done = 1'b1;
				step_out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 160);
			period = $urandom_range(2, 7);
			for (int tick = 0; tick < span; tick++) begin
				case (mode)
					0: step_out_ch.ready <= 1'b1;
					1: step_out_ch.ready <= 1'($urandom_range(0, 1));
					2: step_out_ch.ready <= ($urandom_range(0, 3) == 0);
					default: step_out_ch.ready <= (tick % period == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((step_in_ch.valid && step_in_ch.ready) ||
					(step_out_ch.valid && step_out_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
